FILE: sv/circular_deque_defines.svh
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define CDQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset
`define CDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/cdq_pkg.sv
`default_nettype none

package cdq_pkg;

  localparam int OPCODE_W = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_QUERY      = 3'd4
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic    wr_en;
    logic    pop_ok;
    status_e status;
  } cdq_op_t;

endpackage

`default_nettype wire

FILE: sv/cdq_ram.sv
`default_nettype none

module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

`default_nettype wire

FILE: sv/cdq_idx.sv
`default_nettype none

module cdq_idx #(
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         op_valid_i,
  input  wire logic [cdq_pkg::OPCODE_W-1:0] opcode_i,
  output cdq_pkg::cdq_op_t                  op_o,
  output logic      [AW-1:0]                wr_addr_o,
  output logic      [AW-1:0]                pop_addr_o,
  output logic      [AW-1:0]                front_idx_o,
  output logic      [AW-1:0]                back_last_o,
  output logic      [CW-1:0]                count_o
);

  import cdq_pkg::*;

  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [AW-1:0] front_q, front_d;
  logic [AW-1:0] back_q, back_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          full, empty, wr_req;
  opcode_e       opcode;

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
    return (i == '0) ? LAST_IDX : i - AW'(1);
  endfunction

  assign full   = (cnt_q == FULL_CNT);
  assign empty  = (cnt_q == '0);
  assign opcode = opcode_e'(opcode_i);

  always_comb begin
    front_d    = front_q;
    back_d     = back_q;
    cnt_d      = cnt_q;
    wr_req     = 1'b0;
    op_o.pop_ok = 1'b0;
    op_o.status = ST_DONE;
    wr_addr_o  = back_q;
    pop_addr_o = front_q;
    case (opcode)
      OP_PUSH_FRONT: begin
        if (full) begin
          op_o.status = ST_FULL;
        end else begin
          wr_req    = 1'b1;
          wr_addr_o = idx_dec(front_q);
          front_d   = idx_dec(front_q);
          cnt_d     = cnt_q + CW'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          op_o.status = ST_FULL;
        end else begin
          wr_req    = 1'b1;
          wr_addr_o = back_q;
          back_d    = idx_inc(back_q);
          cnt_d     = cnt_q + CW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          op_o.status = ST_EMPTY;
        end else begin
          op_o.pop_ok = 1'b1;
          pop_addr_o  = front_q;
          front_d     = idx_inc(front_q);
          cnt_d       = cnt_q - CW'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          op_o.status = ST_EMPTY;
        end else begin
          op_o.pop_ok = 1'b1;
          pop_addr_o  = idx_dec(back_q);
          back_d      = idx_dec(back_q);
          cnt_d       = cnt_q - CW'(1);
        end
      end
      default: begin
        op_o.status = ST_DONE;
      end
    endcase
    op_o.wr_en = wr_req & op_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= '0;
      cnt_q   <= '0;
    end else if (op_valid_i) begin
      front_q <= front_d;
      back_q  <= back_d;
      cnt_q   <= cnt_d;
    end
  end

  assign front_idx_o = front_q;
  assign back_last_o = idx_dec(back_q);
  assign count_o     = cnt_q;

endmodule

`default_nettype wire

FILE: sv/circular_deque.sv
// Channel  Dir  tdata fields (low bit up)
// s_axis   in   opcode, item_value
// m_axis   out  popped_value, status, occupancy, is_empty, is_full, front_value, back_value
//
// Each transaction runs through its steps in order: accept (push write or pop read),
// front read, back read, result load; the single read port of the storage RAM sets that order.
// Reset clears the indices, the fill count and the output valid; RAM contents stay
// undefined until written.
// A stalled m_axis holds its result; the next transaction still enters and waits in
// its last step until the output register frees.
`default_nettype none

`include "circular_deque_defines.svh"

module circular_deque #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32,
  localparam int AW        = $clog2(DEPTH),
  localparam int CW        = $clog2(DEPTH + 1),
  localparam int IN_BITS   = cdq_pkg::OPCODE_W + WORD_WIDTH,
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS  = 3 * WORD_WIDTH + cdq_pkg::STATUS_W + CW + 2,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // opcode, item_value
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // popped_value, status, occupancy, is_empty, is_full, front_value, back_value
  output logic      [OUT_W-1:0] m_axis_tdata
);

  import cdq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RFRONT,
    S_RBACK,
    S_DONE
  } state_e;

  state_e                  state_q;
  logic                    in_acc;
  logic                    out_load;
  cdq_op_t                 op;
  logic [AW-1:0]           wr_addr, pop_addr, front_idx, back_last, rd_addr;
  logic [CW-1:0]           count;
  logic [WORD_WIDTH-1:0]   rd_data;
  logic                    pop_ok_q;
  status_e                 status_q;
  logic [WORD_WIDTH-1:0]   popped_q, front_word_q;
  logic                    out_valid_q;
  logic [WORD_WIDTH-1:0]   out_popped_q, out_front_q, out_back_q;
  status_e                 out_status_q;
  logic [CW-1:0]           out_count_q;
  logic                    out_empty_q, out_full_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_load      = (state_q == S_DONE) & (!out_valid_q | m_axis_tready);

  cdq_idx #(
    .DEPTH(DEPTH)
  ) u_idx (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (in_acc),
    .opcode_i   (s_axis_tdata[OPCODE_W-1:0]),
    .op_o       (op),
    .wr_addr_o  (wr_addr),
    .pop_addr_o (pop_addr),
    .front_idx_o(front_idx),
    .back_last_o(back_last),
    .count_o    (count)
  );

  always_comb begin
    case (state_q)
      S_IDLE:   rd_addr = pop_addr;
      S_RFRONT: rd_addr = front_idx;
      S_RBACK:  rd_addr = back_last;
      S_DONE:   rd_addr = back_last;
      default:  rd_addr = front_idx;
    endcase
  end

  cdq_ram #(
    .WIDTH(WORD_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (op.wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(s_axis_tdata[OPCODE_W +: WORD_WIDTH]),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            status_q <= op.status;
            pop_ok_q <= op.pop_ok;
            state_q  <= S_RFRONT;
          end
        end
        S_RFRONT: begin
          popped_q <= pop_ok_q ? rd_data : '0;
          state_q  <= S_RBACK;
        end
        S_RBACK: begin
          front_word_q <= rd_data;
          state_q      <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_popped_q <= popped_q;
            out_status_q <= status_q;
            out_count_q  <= count;
            out_empty_q  <= (count == '0);
            out_full_q   <= (count == CW'(DEPTH));
            out_front_q  <= (count == '0) ? '0 : front_word_q;
            out_back_q   <= (count == '0) ? '0 : rd_data;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_back_q, out_front_q, out_full_q, out_empty_q,
                                 out_count_q, out_status_q, out_popped_q});

  `CDQ_ASSERT_NOW(a_count_range, 1'b1, count <= CW'(DEPTH), "fill count exceeds depth")
  `CDQ_ASSERT_NEXT(a_acc_starts, in_acc, state_q == S_RFRONT, "accepted op did not start")
  `CDQ_ASSERT_NEXT(a_count_hold, !in_acc, $stable(count), "fill count moved without op")

endmodule

`default_nettype wire
